// File: rtl/rowf_pkg.sv
// Shared types and constants for the rank-order window filter.
// Holds field widths, register and rank codes, and the beat structs.
// Has no dependencies; every other file in rtl/ refers to it by scoped name.
package rowf_pkg;

	localparam int PIX_W        = 8;
	localparam int WIDTH_CFG_W  = 11;
	localparam int HEIGHT_CFG_W = 13;
	localparam int RANK_W       = 2;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 13;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RANK_SELECT  = 2'd2;

	// Rank codes; any other code selects the median.
	localparam logic [RANK_W-1:0] RANK_MIN    = 2'd0;
	localparam logic [RANK_W-1:0] RANK_MAX    = 2'd1;
	localparam logic [RANK_W-1:0] RANK_MEDIAN = 2'd2;

	localparam int WIDTH_RESET_VAL  = 640;
	localparam int HEIGHT_RESET_VAL = 480;
	localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [RANK_W-1:0]       RANK_RESET   = RANK_MEDIAN;

	// Output queue sizing.
	localparam int OUT_DEPTH = 8;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// What an item carries down the pipeline besides its pixels.
	typedef struct packed {
		logic produce;  // the item completes a result
		logic full;     // the result window lies fully inside the frame
		logic last;     // the result is the final one of the frame
	} item_flags_t;

	typedef struct packed {
		logic             last;
		logic [PIX_W-1:0] pixel;
	} out_beat_t;

endpackage

// File: rtl/rowf_ctrl.sv
// Configuration registers and frame position counters of the window filter.
// Decides per beat whether it is stored, whether it yields a result and of which kind.
// Depends on rowf_pkg.
module rowf_ctrl #(
	parameter int WINDOW    = 3,
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic [rowf_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [rowf_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  accept,
	input  logic                                  padding,
	output logic                                  item_en,
	output logic                                  store_wr,
	output logic [$clog2(MAX_WIDTH)-1:0]          col,
	output logic [$clog2(WINDOW)-1:0]             slot,
	output rowf_pkg::item_flags_t                 flags,
	output logic [rowf_pkg::RANK_W-1:0]           rank_sel
);

	localparam int RADIUS = (WINDOW - 1) / 2;
	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int HW     = rowf_pkg::HEIGHT_CFG_W;
	localparam int QW     = WW + HW;
	localparam int PW     = QW + 1;
	localparam int SW     = $clog2(WINDOW);
	localparam int CLW    = ((WW > rowf_pkg::WIDTH_CFG_W) ? WW : rowf_pkg::WIDTH_CFG_W) + 1;

	logic [rowf_pkg::WIDTH_CFG_W-1:0]  width_q;
	logic [rowf_pkg::HEIGHT_CFG_W-1:0] height_q;
	logic [rowf_pkg::RANK_W-1:0]       rank_q;
	logic [WW-1:0]                     weff;
	logic [HW-1:0]                     heff;
	logic [QW-1:0]                     total;
	logic [PW-1:0]                     lag;
	logic [PW-1:0]                     pos_q;
	logic [QW-1:0]                     oidx_q;
	logic [CW-1:0]                     col_q;
	logic [CW-1:0]                     ocol_q;
	logic [HW-1:0]                     orow_q;
	logic [SW-1:0]                     slot_q;
	logic                              in_frame;
	logic                              proc;
	logic                              produce;
	logic                              last;
	logic                              full;
	logic                              col_wrap;
	logic                              ocol_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rowf_pkg::WIDTH_RESET;
			height_q <= rowf_pkg::HEIGHT_RESET;
			rank_q   <= rowf_pkg::RANK_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				rowf_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[rowf_pkg::WIDTH_CFG_W-1:0];
				rowf_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[rowf_pkg::HEIGHT_CFG_W-1:0];
				rowf_pkg::REG_RANK_SELECT:  rank_q   <= cfg_data[rowf_pkg::RANK_W-1:0];
				default: ;
			endcase
		end
	end

	// Sizes clamped to what the hardware supports.
	always_comb begin
		if (width_q == '0) begin
			weff = WW'(1);
		end else if (CLW'(width_q) > CLW'(MAX_WIDTH)) begin
			weff = WW'(MAX_WIDTH);
		end else begin
			weff = WW'(width_q);
		end
		heff = (height_q == '0) ? HW'(1) : height_q;
	end

	// Frame size and output lag follow the registers directly, so a beat taken
	// right after a register write already sees the new sizes.
	always_comb begin
		total = QW'(weff) * QW'(heff);
		lag   = PW'(weff) * PW'(RADIUS) + PW'(RADIUS);
	end

	always_comb begin
		in_frame  = pos_q < PW'(total);
		proc      = !(in_frame && padding);
		produce   = proc && (pos_q >= lag);
		last      = (PW'(oidx_q) + PW'(1)) >= PW'(total);
		col_wrap  = (WW'(col_q) + WW'(1)) >= weff;
		ocol_wrap = (WW'(ocol_q) + WW'(1)) >= weff;
		full      = (orow_q >= HW'(RADIUS)) && (ocol_q >= CW'(RADIUS))
		         && ((HW+1)'(orow_q) + (HW+1)'(RADIUS) < (HW+1)'(heff))
		         && ((WW+1)'(ocol_q) + (WW+1)'(RADIUS) < (WW+1)'(weff));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			oidx_q <= '0;
			col_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			slot_q <= '0;
		end else if (item_en) begin
			if (produce && last) begin
				pos_q  <= '0;
				oidx_q <= '0;
				col_q  <= '0;
				ocol_q <= '0;
				orow_q <= '0;
				slot_q <= '0;
			end else begin
				pos_q <= pos_q + PW'(1);
				if (col_wrap) begin
					col_q  <= '0;
					slot_q <= (slot_q == SW'(WINDOW - 1)) ? '0 : slot_q + SW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
				if (produce) begin
					oidx_q <= oidx_q + QW'(1);
					if (ocol_wrap) begin
						ocol_q <= '0;
						orow_q <= orow_q + HW'(1);
					end else begin
						ocol_q <= ocol_q + CW'(1);
					end
				end
			end
		end
	end

	assign item_en       = accept && proc;
	assign store_wr      = in_frame;
	assign col           = col_q;
	assign slot          = slot_q;
	assign flags.produce = produce;
	assign flags.full    = full;
	assign flags.last    = last;
	assign rank_sel      = rank_q;

endmodule

// File: rtl/rowf_line_buf.sv
// Line store of the window filter: one bank per ring row, read at the beat's column.
// Delivers one window column (oldest row first, the incoming pixel last) per beat.
// Depends on rowf_pkg.
module rowf_line_buf #(
	parameter int WINDOW    = 3,
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           item_en,
	input  logic                                           store_wr,
	input  logic [$clog2(MAX_WIDTH)-1:0]                   col,
	input  logic [$clog2(WINDOW)-1:0]                      slot,
	input  logic [rowf_pkg::PIX_W-1:0]                     pixel,
	input  rowf_pkg::item_flags_t                          flags,
	output logic                                           valid_s1,
	output rowf_pkg::item_flags_t                          flags_s1,
	output logic [WINDOW-1:0][rowf_pkg::PIX_W-1:0]         column
);

	localparam int SW = $clog2(WINDOW);

	logic [rowf_pkg::PIX_W-1:0]              mem [WINDOW][MAX_WIDTH];
	logic [WINDOW-1:0][rowf_pkg::PIX_W-1:0]  rd_s1;
	logic [SW-1:0]                           slot_s1;
	logic [rowf_pkg::PIX_W-1:0]              pixel_s1;

	always_ff @(posedge clk) begin
		for (int k = 0; k < WINDOW; k++) begin
			if (item_en && store_wr && (slot == SW'(k))) begin
				mem[k][col] <= pixel;
			end
			if (item_en) begin
				rd_s1[k] <= mem[k][col];
			end
		end
		if (item_en) begin
			slot_s1  <= slot;
			pixel_s1 <= pixel;
			flags_s1 <= flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= item_en;
		end
	end

	// Entry k holds the row WINDOW-1-k rows above the incoming one, whose ring
	// slot is (slot + 1 + k) mod WINDOW.
	always_comb begin
		logic [SW:0] idx;
		idx = '0;
		for (int k = 0; k < WINDOW - 1; k++) begin
			idx = (SW+1)'(slot_s1) + (SW+1)'(k + 1);
			if (idx >= (SW+1)'(WINDOW)) begin
				idx = idx - (SW+1)'(WINDOW);
			end
			column[k] = rd_s1[idx[SW-1:0]];
		end
		column[WINDOW-1] = pixel_s1;
	end

endmodule

// File: rtl/rowf_rank.sv
// Window registers and rank selection of the window filter.
// Ranks every window value in one stage, picks the requested rank in the next.
// Depends on rowf_pkg.
module rowf_rank #(
	parameter int WINDOW = 3
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    valid_s1,
	input  rowf_pkg::item_flags_t                   flags_s1,
	input  logic [WINDOW-1:0][rowf_pkg::PIX_W-1:0]  column,
	input  logic [rowf_pkg::RANK_W-1:0]             rank_sel,
	output logic                                    push,
	output rowf_pkg::out_beat_t                     push_beat
);

	localparam int RADIUS = (WINDOW - 1) / 2;
	localparam int N      = WINDOW * WINDOW;
	localparam int RKW    = $clog2(N);

	logic [WINDOW-1:0][WINDOW-1:0][rowf_pkg::PIX_W-1:0] win_q;
	logic                                  valid_s2;
	rowf_pkg::item_flags_t                 flags_s2;
	logic [N-1:0][rowf_pkg::PIX_W-1:0]     vals;
	logic [N-1:0][RKW-1:0]                 ranks;
	logic [RKW-1:0]                        target;
	logic                                  valid_s3;
	rowf_pkg::item_flags_t                 flags_s3;
	logic [N-1:0][rowf_pkg::PIX_W-1:0]     val_s3;
	logic [N-1:0][RKW-1:0]                 rank_s3;
	logic [RKW-1:0]                        target_s3;
	logic [rowf_pkg::PIX_W-1:0]            center_s3;
	logic [rowf_pkg::PIX_W-1:0]            sel;

	// The window slides one column per processed beat; the newest column sits last.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int c = 0; c < WINDOW - 1; c++) begin
				win_q[c] <= win_q[c+1];
			end
			win_q[WINDOW-1] <= column;
			flags_s2        <= flags_s1;
		end
	end

	always_comb begin
		for (int a = 0; a < WINDOW; a++) begin
			for (int b = 0; b < WINDOW; b++) begin
				vals[a*WINDOW+b] = win_q[a][b];
			end
		end
	end

	// Rank of a value: count of smaller values, ties broken by position, so
	// every rank from zero to N-1 is held by exactly one entry.
	always_comb begin
		logic [RKW-1:0] cnt;
		cnt = '0;
		for (int i = 0; i < N; i++) begin
			cnt = '0;
			for (int j = 0; j < N; j++) begin
				if ((vals[j] < vals[i]) || ((j < i) && (vals[j] == vals[i]))) begin
					cnt = cnt + RKW'(1);
				end
			end
			ranks[i] = cnt;
		end
	end

	always_comb begin
		case (rank_sel)
			rowf_pkg::RANK_MIN: target = '0;
			rowf_pkg::RANK_MAX: target = RKW'(N - 1);
			default:            target = RKW'((N - 1) / 2);
		endcase
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			val_s3    <= vals;
			rank_s3   <= ranks;
			target_s3 <= target;
			center_s3 <= win_q[RADIUS][RADIUS];
			flags_s3  <= flags_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		sel = '0;
		for (int i = 0; i < N; i++) begin
			if (rank_s3[i] == target_s3) begin
				sel = sel | val_s3[i];
			end
		end
	end

	assign push            = valid_s3 && flags_s3.produce;
	assign push_beat.pixel = flags_s3.full ? sel : center_s3;
	assign push_beat.last  = flags_s3.last;

endmodule

// File: rtl/rowf_out_fifo.sv
// Small result queue that decouples the filter pipeline from the output stream.
// Depth comes from rowf_pkg; the caller keeps it from overflowing.
// Depends on rowf_pkg.
module rowf_out_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  rowf_pkg::out_beat_t         push_beat,
	output logic                        tvalid,
	input  logic                        tready,
	output logic [rowf_pkg::PIX_W-1:0]  tdata,
	output logic                        tlast
);

	rowf_pkg::out_beat_t                 mem_q [rowf_pkg::OUT_DEPTH];
	logic [rowf_pkg::OUT_PTR_W-1:0]      wptr_q;
	logic [rowf_pkg::OUT_PTR_W-1:0]      rptr_q;
	logic [rowf_pkg::OUT_CNT_W-1:0]      count_q;
	logic                                pop;

	assign pop = tvalid && tready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == rowf_pkg::OUT_PTR_W'(rowf_pkg::OUT_DEPTH - 1))
				        ? '0 : wptr_q + rowf_pkg::OUT_PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == rowf_pkg::OUT_PTR_W'(rowf_pkg::OUT_DEPTH - 1))
				        ? '0 : rptr_q + rowf_pkg::OUT_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + rowf_pkg::OUT_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - rowf_pkg::OUT_CNT_W'(1);
			end
		end
	end

	assign tvalid = count_q != '0;
	assign tdata  = mem_q[rptr_q].pixel;
	assign tlast  = mem_q[rptr_q].last;

endmodule

// File: rtl/rank_order_window_filter_core.sv
// Rank-order (min / max / median) window filter over 8-bit greyscale raster pixels.
// A result passes the read, window and rank registers and the output queue to m_tvalid.
// Throughput: one beat per cycle in and out while m_tready stays high; the path is
// line-store read, window shift, ranking of all window values, rank select, output queue.
// Reset: arst_n clears counters, pipeline valids and queue and restores the registers;
// the line store is not cleared and needs no clearing pass, so beats are taken at once.
module rank_order_window_filter_core #(
	parameter int WINDOW    = 3,
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [rowf_pkg::PIX_W-1:0]          s_tdata,   // [7:0] pixel_in
	input  logic                                s_tuser,   // [0] padding
	// Output stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rowf_pkg::PIX_W-1:0]          m_tdata,   // [7:0] pixel_out
	output logic                                m_tlast,   // last_of_frame
	// Configuration writes.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rowf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [rowf_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// The filter keeps WINDOW rows of MAX_WIDTH pixels in a ring, one memory bank
	// per ring row. Each processed beat reads the WINDOW-1 older rows at its column,
	// writes its own pixel while inside the frame, and the column slides into the window. The
	// result for raster position q is produced by the beat at position
	// q + RADIUS*width + RADIUS, whose window is then centered on q. Border pixels
	// are taken from the window center, which is the stored pixel at q.

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int SW = $clog2(WINDOW);

	logic                                     accept;
	logic                                     item_en;
	logic                                     store_wr;
	logic [CW-1:0]                            col;
	logic [SW-1:0]                            slot;
	rowf_pkg::item_flags_t                    flags;
	logic [rowf_pkg::RANK_W-1:0]              rank_sel;
	logic                                     valid_s1;
	rowf_pkg::item_flags_t                    flags_s1;
	logic [WINDOW-1:0][rowf_pkg::PIX_W-1:0]   column;
	logic                                     push;
	rowf_pkg::out_beat_t                      push_beat;
	logic [rowf_pkg::OUT_CNT_W-1:0]           credit_q;
	logic                                     credit_inc;
	logic                                     credit_dec;

	// Registers are always writable.
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	rowf_ctrl #(
		.WINDOW    (WINDOW),
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.padding   (s_tuser),
		.item_en   (item_en),
		.store_wr  (store_wr),
		.col       (col),
		.slot      (slot),
		.flags     (flags),
		.rank_sel  (rank_sel)
	);

	rowf_line_buf #(
		.WINDOW    (WINDOW),
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_en  (item_en),
		.store_wr (store_wr),
		.col      (col),
		.slot     (slot),
		.pixel    (s_tdata),
		.flags    (flags),
		.valid_s1 (valid_s1),
		.flags_s1 (flags_s1),
		.column   (column)
	);

	rowf_rank #(
		.WINDOW (WINDOW)
	) u_rank (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.flags_s1  (flags_s1),
		.column    (column),
		.rank_sel  (rank_sel),
		.push      (push),
		.push_beat (push_beat)
	);

	rowf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_beat (push_beat),
		.tvalid    (m_tvalid),
		.tready    (m_tready),
		.tdata     (m_tdata),
		.tlast     (m_tlast)
	);

	// Every accepted beat that will yield a result takes a credit, returned when
	// the result beat leaves. With credits equal to the queue depth, results in
	// flight plus results queued never exceed the queue, and the pipeline never
	// has to stall. The queue is deep enough to cover the pipeline, so a steady
	// stream runs at one beat per cycle while m_tready stays high.
	assign credit_inc = item_en && flags.produce;
	assign credit_dec = m_tvalid && m_tready;
	assign s_tready   = credit_q < rowf_pkg::OUT_CNT_W'(rowf_pkg::OUT_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (credit_inc && !credit_dec) begin
			credit_q <= credit_q + rowf_pkg::OUT_CNT_W'(1);
		end else if (credit_dec && !credit_inc) begin
			credit_q <= credit_q - rowf_pkg::OUT_CNT_W'(1);
		end
	end

	// Credits can never exceed the queue depth.
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= rowf_pkg::OUT_CNT_W'(rowf_pkg::OUT_DEPTH))
		else $error("credit count above queue depth");

	// A queued result always holds a credit.
	a_credit_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (credit_q != '0))
		else $error("result queued without a credit");

	// A completing beat reaches the queue past the read, window and rank registers.
	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		credit_inc |-> ##3 push)
		else $error("result did not reach the output queue in time");

endmodule

// File: tb/rank_order_window_filter_checker.sv
// Checker for the rank-order window filter: watches the config, input and output channels.
// Keeps its own line rows and counters, predicts each output beat and compares it.
// Depends on rowf_pkg for widths, register indexes and rank codes.
module rank_order_window_filter_checker #(
	parameter int WINDOW    = 3,
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [rowf_pkg::PIX_W-1:0]          s_tdata,   // [7:0] pixel_in
	input  logic                                s_tuser,   // [0] padding
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [rowf_pkg::PIX_W-1:0]          m_tdata,   // [7:0] pixel_out
	input  logic                                m_tlast,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [rowf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [rowf_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                  outstanding,
	output int                                  fail_count
);

	localparam int RADIUS   = (WINDOW - 1) / 2;
	localparam int WIN_AREA = WINDOW * WINDOW;

	logic [rowf_pkg::PIX_W-1:0]        row_ring [WINDOW*MAX_WIDTH];
	int unsigned                       row_pos;
	int unsigned                       col_pos;
	int unsigned                       next_out;
	logic [rowf_pkg::WIDTH_CFG_W-1:0]  width_reg;
	logic [rowf_pkg::HEIGHT_CFG_W-1:0] height_reg;
	logic [rowf_pkg::RANK_W-1:0]       rank_reg;
	rowf_pkg::out_beat_t               pending_pixels [$];
	int                                mismatches = 0;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t: mismatch: %s", $time, what);
	endtask

	function automatic int unsigned active_width();
		if (width_reg == '0) return 1;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return 32'(width_reg);
	endfunction

	function automatic int unsigned active_height();
		return (height_reg == '0) ? 1 : 32'(height_reg);
	endfunction

	function automatic logic [rowf_pkg::PIX_W-1:0] ring_read(input int unsigned row,
			input int unsigned col);
		int unsigned idx;
		idx = (row % WINDOW) * MAX_WIDTH + col;
		return (idx < WINDOW * MAX_WIDTH) ? row_ring[idx] : '0;
	endfunction

	// Picks the k-th smallest window value by counting, which handles ties directly.
	function automatic logic [rowf_pkg::PIX_W-1:0] window_rank(input int unsigned orow,
			input int unsigned ocol);
		logic [rowf_pkg::PIX_W-1:0] vals [WIN_AREA];
		int                         k, lt, le, i, j, n;
		n = 0;
		for (i = 0; i < WINDOW; i++) begin
			for (j = 0; j < WINDOW; j++) begin
				vals[n] = ring_read(orow - RADIUS + i, ocol - RADIUS + j);
				n++;
			end
		end
		case (rank_reg)
			rowf_pkg::RANK_MIN: k = 0;
			rowf_pkg::RANK_MAX: k = WIN_AREA - 1;
			default:            k = (WIN_AREA - 1) / 2;
		endcase
		for (i = 0; i < WIN_AREA; i++) begin
			lt = 0;
			le = 0;
			for (j = 0; j < WIN_AREA; j++) begin
				if (vals[j] < vals[i]) lt++;
				if (vals[j] <= vals[i]) le++;
			end
			if (lt <= k && k < le) return vals[i];
		end
		return vals[0];
	endfunction

	task automatic filter_pixel_beat(input logic [rowf_pkg::PIX_W-1:0] pix, input logic pad);
		int unsigned         w, h, total, lag, p, q, orow, ocol;
		rowf_pkg::out_beat_t beat;
		w     = active_width();
		h     = active_height();
		total = w * h;
		lag   = RADIUS * w + RADIUS;
		p     = row_pos * w + col_pos;
		if (p < total && pad) return;
		if (p < total && col_pos < w) row_ring[(row_pos % WINDOW) * MAX_WIDTH + col_pos] = pix;
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos++;
		end else begin
			col_pos++;
		end
		if (p < lag) return;
		q    = next_out;
		orow = q / w;
		ocol = q % w;
		if (orow >= RADIUS && ocol >= RADIUS && orow + RADIUS < h && ocol + RADIUS < w) begin
			beat.pixel = window_rank(orow, ocol);
		end else begin
			beat.pixel = ring_read(orow, ocol);
		end
		beat.last = (q + 1 >= total);
		if (beat.last) begin
			row_pos  = 0;
			col_pos  = 0;
			next_out = 0;
		end else begin
			next_out++;
		end
		pending_pixels = {pending_pixels, beat};
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rowf_pkg::out_beat_t want;
		if (!arst_n) begin
			row_pos    = 0;
			col_pos    = 0;
			next_out   = 0;
			width_reg  = rowf_pkg::WIDTH_RESET;
			height_reg = rowf_pkg::HEIGHT_RESET;
			rank_reg   = rowf_pkg::RANK_RESET;
			pending_pixels.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_pixels.size() == 0) begin
					report_mismatch($sformatf("output beat %0d with nothing expected", m_tdata));
				end else begin
					want = pending_pixels.pop_front();
					if (m_tdata !== want.pixel)
						report_mismatch($sformatf("pixel_out %0d, expected %0d",
							m_tdata, want.pixel));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("last_of_frame %0b, expected %0b",
							m_tlast, want.last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rowf_pkg::REG_IMAGE_WIDTH:
						width_reg = cfg_data[rowf_pkg::WIDTH_CFG_W-1:0];
					rowf_pkg::REG_IMAGE_HEIGHT:
						height_reg = cfg_data[rowf_pkg::HEIGHT_CFG_W-1:0];
					rowf_pkg::REG_RANK_SELECT:
						rank_reg = cfg_data[rowf_pkg::RANK_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) filter_pixel_beat(s_tdata, s_tuser);
		end
		outstanding <= pending_pixels.size();
	end

endmodule

// File: tb/rank_order_window_filter_core_test.sv
// Top of the rank-order window filter testbench: clock, reset, stimulus and verdict.
// Drives frames through the core and leaves prediction and comparison to the checker.
// Depends on rowf_pkg, rank_order_window_filter_core and rank_order_window_filter_checker.
module rank_order_window_filter_core_test;

	localparam int WINDOW         = 3;
	localparam int MAX_WIDTH      = 1024;
	localparam int RADIUS         = (WINDOW - 1) / 2;
	localparam int CLK_PERIOD     = 8;
	localparam int RANDOM_ITEMS   = 1350;
	// The core offers a result after its pipeline registers; allow some margin.
	localparam int SETTLE_CYCLES  = 8;
	localparam int LONG_HOLD      = 400;
	localparam int TIMEOUT_CYCLES = 5_000_000;
	// Code 3 has no name in the package; the core treats it as the median.
	localparam logic [rowf_pkg::RANK_W-1:0] RANK_UNUSED = 2'd3;

	typedef enum int {PAT_NOISE, PAT_EXTREME, PAT_TIES, PAT_RAMP} pattern_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	logic [rowf_pkg::PIX_W-1:0]       s_tdata   = '0;    // [7:0] pixel_in
	logic                             s_tuser   = 1'b0;  // [0] padding
	logic                             m_tvalid;
	logic                             m_tready  = 1'b0;
	logic [rowf_pkg::PIX_W-1:0]       m_tdata;           // [7:0] pixel_out
	logic                             m_tlast;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [rowf_pkg::CFG_INDEX_W-1:0] cfg_index = rowf_pkg::REG_IMAGE_WIDTH;
	logic [rowf_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

	int outstanding;
	int fail_count;
	int items_sent;
	bit src_steady = 1'b0;   // when set, the sender offers a beat every cycle
	bit choke_req  = 1'b0;   // asks the receiver for its one long hold-off

	rank_order_window_filter_core #(
		.WINDOW    (WINDOW),
		.MAX_WIDTH (MAX_WIDTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rank_order_window_filter_checker #(
		.WINDOW    (WINDOW),
		.MAX_WIDTH (MAX_WIDTH)
	) pixel_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog: a hung handshake or a result that never arrives ends here.
	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("FAIL rank_order_window_filter_core");
		$finish;
	end

	// Mostly no gap or a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [rowf_pkg::PIX_W-1:0] pick_pixel(input pattern_t pat,
			input int i);
		logic [rowf_pkg::PIX_W-1:0] v;
		case (pat)
			PAT_EXTREME: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			PAT_TIES:    v = rowf_pkg::PIX_W'(100 + $urandom_range(0, 2));
			PAT_RAMP:    v = rowf_pkg::PIX_W'(i * 7);
			default:     v = rowf_pkg::PIX_W'($urandom_range(0, 255));
		endcase
		return v;
	endfunction

	// Receiver. It stalls at random in some stretches and not at all in others, and once,
	// when asked, holds off for a long time so that the core backs up into its input.
	initial begin : sink
		int hold_left;
		bit stall_mode;
		bit choke_taken;
		hold_left   = 0;
		stall_mode  = 1'b1;
		choke_taken = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (choke_req && !choke_taken) begin
				choke_taken = 1'b1;
				hold_left   = LONG_HOLD;
			end else if (hold_left == 0 && stall_mode && $urandom_range(0, 3) == 0) begin
				hold_left = pick_gap();
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			if ($urandom_range(0, 199) == 0) stall_mode = !stall_mode;
		end
	end

	// Offers one beat after an optional gap and returns at the edge that takes it. The valid
	// stays high afterwards, so the caller either sends again or lowers it in the same step.
	task automatic send_beat(input logic [rowf_pkg::PIX_W-1:0] pix, input logic pad);
		int gap;
		gap = src_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		s_tuser  <= pad;
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	// Waits until every predicted output beat has been seen. The first edge lets the
	// checker's count catch up with a beat taken at the current edge.
	task automatic drain();
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Writes all three registers as one burst on the config channel; only called while idle.
	task automatic configure(input logic [rowf_pkg::CFG_DATA_W-1:0] w_set,
			input logic [rowf_pkg::CFG_DATA_W-1:0] h_set,
			input logic [rowf_pkg::RANK_W-1:0] rank);
		cfg_valid <= 1'b1;
		cfg_index <= rowf_pkg::REG_IMAGE_WIDTH;
		cfg_data  <= w_set;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_index <= rowf_pkg::REG_IMAGE_HEIGHT;
		cfg_data  <= h_set;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_index <= rowf_pkg::REG_RANK_SELECT;
		cfg_data  <= rowf_pkg::CFG_DATA_W'(rank);
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// A 3x3 frame with one full window in the middle. Each value but the last has one bit set
	// (or cleared, when inverted), so every data bit toggles. A padding beat lands inside
	// the frame, where the core must drop it, and the first tail beat carries a pixel.
	task automatic play_tile(input logic [rowf_pkg::RANK_W-1:0] rank, input bit invert);
		logic [rowf_pkg::PIX_W-1:0] pix;
		int                         i;
		repeat (SETTLE_CYCLES) @(posedge clk);
		configure(rowf_pkg::CFG_DATA_W'(3), rowf_pkg::CFG_DATA_W'(3), rank);
		for (i = 0; i < 9; i++) begin
			if (i == 4) send_beat(8'h5A, 1'b1);
			pix = (i < 8) ? (8'd1 << i) : 8'd0;
			send_beat(invert ? ~pix : pix, 1'b0);
		end
		send_beat(8'hC3, 1'b0);
		for (i = 0; i < 3; i++) send_beat(8'h00, 1'b1);
		s_tvalid <= 1'b0;
		drain();
	endtask

	// One whole frame: the pixels, then the flush beats that push out the tail.
	task automatic run_frame(input int w_set, input int h_set,
			input logic [rowf_pkg::RANK_W-1:0] rank, input pattern_t pat,
			input bit pause_mid, input bit choke);
		int w, h, n_pix, n_flush, i;
		w       = (w_set < 1) ? 1 : ((w_set > MAX_WIDTH) ? MAX_WIDTH : w_set);
		h       = (h_set < 1) ? 1 : h_set;
		n_pix   = w * h;
		n_flush = RADIUS * w + RADIUS;
		repeat (SETTLE_CYCLES) @(posedge clk);
		configure(rowf_pkg::CFG_DATA_W'(w_set), rowf_pkg::CFG_DATA_W'(h_set), rank);
		src_steady = ($urandom_range(0, 3) == 0);
		if (choke) choke_req <= 1'b1;
		for (i = 0; i < n_pix; i++) begin
			// Stray padding beats inside the frame are ignored by the core.
			if ($urandom_range(0, 39) == 0) send_beat(pick_pixel(PAT_NOISE, i), 1'b1);
			send_beat(pick_pixel(pat, i), 1'b0);
			items_sent++;
			if (pause_mid && i == n_pix / 2) begin
				// Sender goes quiet until every result so far has come out.
				s_tvalid <= 1'b0;
				drain();
			end
		end
		// Tail beats mostly carry padding; a plain pixel here also counts as a flush.
		for (i = 0; i < n_flush; i++) begin
			send_beat(pick_pixel(PAT_NOISE, i), $urandom_range(0, 3) != 0);
			items_sent++;
		end
		s_tvalid <= 1'b0;
		drain();
	endtask

	initial begin : stimulus
		int                          w_set, h_set, frame_no;
		logic [rowf_pkg::RANK_W-1:0] rank;
		pattern_t                    pat;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: minimum and maximum over one full window, then the smallest
		// frame with zero width and height and the unnamed rank code.
		play_tile(rowf_pkg::RANK_MIN, 1'b1);
		play_tile(rowf_pkg::RANK_MAX, 1'b0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		configure('0, '0, RANK_UNUSED);
		send_beat(8'hA5, 1'b0);
		send_beat(8'h3C, 1'b1);
		send_beat(8'h5A, 1'b0);
		s_tvalid <= 1'b0;
		drain();

		// Random part: mostly frames with full windows, some too small for any window,
		// a few wider ones, every rank code and several pixel patterns.
		items_sent = 0;
		frame_no   = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 19))
				0, 1, 2: begin
					w_set = $urandom_range(0, 2);
					h_set = $urandom_range(0, 5);
				end
				3, 4: begin
					w_set = $urandom_range(3, 8);
					h_set = $urandom_range(0, 2);
				end
				5: begin
					w_set = $urandom_range(11, 40);
					h_set = $urandom_range(3, 6);
				end
				default: begin
					w_set = $urandom_range(3, 10);
					h_set = $urandom_range(3, 8);
				end
			endcase
			rank = rowf_pkg::RANK_W'($urandom_range(0, 3));
			pat  = pattern_t'($urandom_range(0, 3));
			run_frame(w_set, h_set, rank, pat, frame_no == 0 || $urandom_range(0, 9) == 0, 1'b0);
			frame_no++;
		end

		// A wide frame with the long receiver hold-off, so the queue fills and the
		// input stalls while the sender keeps offering beats.
		run_frame(40, 6, rowf_pkg::RANK_MEDIAN, PAT_NOISE, 1'b0, 1'b1);

		// Any stray beat the core still emits shows up in the checker during this wait.
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS rank_order_window_filter_core");
		end else begin
			$display("FAIL rank_order_window_filter_core");
		end
		$finish;
	end

endmodule
